// ===== design/stream_find_and_replace_defines.svh =====
// ----------------------------------------------------------------------------
// Stream find-and-replace assertion macros
// Shared property shorthands for the checks closing the front, queue and back.
// ----------------------------------------------------------------------------
`ifndef STREAM_FIND_AND_REPLACE_DEFINES_SVH
`define STREAM_FIND_AND_REPLACE_DEFINES_SVH

// Same-cycle implication, checked on every clock outside reset.
`define SFR_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clock outside reset.
`define SFR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/sfr_pkg.sv =====
// ----------------------------------------------------------------------------
// sfr_pkg
// Types, widths and register codes shared by the find-and-replace modules.
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam int DATA_W     = 64;
  localparam int ADDR_W     = 6;
  localparam int LEN_W      = 4;
  localparam int CNT_W      = 16;
  localparam int EMIT_BYTES = 8;
  localparam int EMIT_W     = 8 * EMIT_BYTES;
  localparam int EMIT_IDX_W = $clog2(EMIT_BYTES);

  localparam int MAX_PATTERN_BYTES = 8;
  localparam logic [LEN_W-1:0] MAX_REPLACE_BYTES = 4'd8;
  localparam int QUEUE_DEPTH = 2;

  // register index, taken from paddr[5:3]
  localparam logic [2:0] REG_PATTERN_BYTES      = 3'd0;
  localparam logic [2:0] REG_PATTERN_LENGTH     = 3'd1;
  localparam logic [2:0] REG_REPLACEMENT_BYTES  = 3'd2;
  localparam logic [2:0] REG_REPLACEMENT_LENGTH = 3'd3;
  localparam logic [2:0] REG_MAX_REPLACEMENTS   = 3'd4;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_string;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_present;
    logic       out_last;
  } out_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] pattern_bytes;
    logic [LEN_W-1:0]  pattern_length;
    logic [DATA_W-1:0] replacement_bytes;
    logic [LEN_W-1:0]  replacement_length;
    logic [CNT_W-1:0]  max_replacements;
  } cfg_t;

  // one item's worth of work for the back end
  typedef struct packed {
    logic [EMIT_W-1:0] emit_bytes;
    logic [LEN_W-1:0]  emit_count;
    logic              last;
  } cmd_t;

endpackage

// ===== design/sfr_regs.sv =====
// ----------------------------------------------------------------------------
// sfr_regs
// APB-style configuration registers with read-back.
// ----------------------------------------------------------------------------
module sfr_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sfr_pkg::ADDR_W-1:0] paddr,
  input  logic [sfr_pkg::DATA_W-1:0] pwdata,
  output logic [sfr_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output sfr_pkg::cfg_t              cfg
);

  sfr_pkg::cfg_t cfg_r;
  sfr_pkg::cfg_t cfg_nxt;
  logic          wr_en;
  logic [2:0]    reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[5:3];
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        sfr_pkg::REG_PATTERN_BYTES:      cfg_nxt.pattern_bytes = pwdata;
        sfr_pkg::REG_PATTERN_LENGTH:
          cfg_nxt.pattern_length = pwdata[sfr_pkg::LEN_W-1:0];
        sfr_pkg::REG_REPLACEMENT_BYTES:  cfg_nxt.replacement_bytes = pwdata;
        sfr_pkg::REG_REPLACEMENT_LENGTH:
          cfg_nxt.replacement_length = pwdata[sfr_pkg::LEN_W-1:0];
        sfr_pkg::REG_MAX_REPLACEMENTS:
          cfg_nxt.max_replacements = pwdata[sfr_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pattern_bytes      <= '0;
      cfg_r.pattern_length     <= sfr_pkg::LEN_W'(1);
      cfg_r.replacement_bytes  <= '0;
      cfg_r.replacement_length <= '0;
      cfg_r.max_replacements   <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (reg_idx)
      sfr_pkg::REG_PATTERN_BYTES:      prdata = cfg_r.pattern_bytes;
      sfr_pkg::REG_PATTERN_LENGTH:
        prdata = sfr_pkg::DATA_W'(cfg_r.pattern_length);
      sfr_pkg::REG_REPLACEMENT_BYTES:  prdata = cfg_r.replacement_bytes;
      sfr_pkg::REG_REPLACEMENT_LENGTH:
        prdata = sfr_pkg::DATA_W'(cfg_r.replacement_length);
      sfr_pkg::REG_MAX_REPLACEMENTS:
        prdata = sfr_pkg::DATA_W'(cfg_r.max_replacements);
      default:                         prdata = '0;
    endcase
  end

endmodule

// ===== design/sfr_front.sv =====
// ----------------------------------------------------------------------------
// sfr_front
// Accept text items, keep the match window, issue up to one command per item.
// ----------------------------------------------------------------------------
`include "stream_find_and_replace_defines.svh"

module sfr_front #(
  parameter int MAX_PATTERN_BYTES = sfr_pkg::MAX_PATTERN_BYTES
) (
  input  logic              clk,
  input  logic              rst_n,
  input  sfr_pkg::cfg_t     cfg,
  input  logic              push,
  output logic              full,
  input  sfr_pkg::in_item_t in_data,
  output logic              q_push,
  output sfr_pkg::cmd_t     q_cmd,
  input  logic              q_full
);

  localparam int P  = MAX_PATTERN_BYTES;
  localparam int HW = $clog2(P + 1);
  localparam int LW = sfr_pkg::LEN_W;

  logic [7:0]               win_r   [P];
  logic [7:0]               win_nxt [P];
  logic [7:0]               nw      [P];
  logic [8*P-1:0]           nw_flat;
  logic [8*P-1:0]           shifted;
  logic [HW-1:0]            held_r, held_nxt, cnt_new;
  logic [sfr_pkg::CNT_W-1:0] done_r, done_nxt;
  logic [LW-1:0]            cnt_ext, plen_eff, rlen_eff, pop_cnt, emit_cnt;
  logic [LW+2:0]            shamt;
  logic                     in_accept, eos, win_full, bytes_eq, match, cmd_valid;

  assign eos       = in_data.end_of_string;
  assign full      = q_full;
  assign in_accept = push && !q_full;
  assign cnt_new   = held_r + HW'(1);
  assign cnt_ext   = LW'(cnt_new);

  // clamp lengths to what the window and command can hold
  always_comb begin
    if (cfg.pattern_length == '0) begin
      plen_eff = LW'(1);
    end else if (cfg.pattern_length > LW'(P)) begin
      plen_eff = LW'(P);
    end else begin
      plen_eff = cfg.pattern_length;
    end
    if (cfg.replacement_length > sfr_pkg::MAX_REPLACE_BYTES) begin
      rlen_eff = sfr_pkg::MAX_REPLACE_BYTES;
    end else begin
      rlen_eff = cfg.replacement_length;
    end
  end

  // window with the new byte appended
  always_comb begin
    for (int i = 0; i < P; i++) begin
      nw[i] = (HW'(i) == held_r) ? in_data.text_byte : win_r[i];
      nw_flat[8*i +: 8] = nw[i];
    end
  end

  always_comb begin
    bytes_eq = 1'b1;
    for (int i = 0; i < P; i++) begin
      if ((LW'(i) < plen_eff) && (nw[i] != cfg.pattern_bytes[8*i +: 8])) begin
        bytes_eq = 1'b0;
      end
    end
  end

  assign win_full = (cnt_ext >= plen_eff);
  assign match    = (cnt_ext == plen_eff) && (done_r < cfg.max_replacements) && bytes_eq;
  assign pop_cnt  = cnt_ext - plen_eff + LW'(1);

  always_comb begin
    if (match) begin
      emit_cnt = rlen_eff;
    end else if (eos) begin
      emit_cnt = cnt_ext;
    end else if (win_full) begin
      emit_cnt = pop_cnt;
    end else begin
      emit_cnt = '0;
    end
  end

  // drop the emitted oldest bytes
  assign shamt   = {emit_cnt, 3'b000};
  assign shifted = nw_flat >> shamt;

  always_comb begin
    for (int i = 0; i < P; i++) begin
      win_nxt[i] = shifted[8*i +: 8];
    end
  end

  always_comb begin
    if (match || eos) begin
      held_nxt = '0;
    end else if (win_full) begin
      held_nxt = HW'(plen_eff - LW'(1));
    end else begin
      held_nxt = cnt_new;
    end
    if (eos) begin
      done_nxt = '0;
    end else if (match) begin
      done_nxt = done_r + sfr_pkg::CNT_W'(1);
    end else begin
      done_nxt = done_r;
    end
  end

  assign cmd_valid        = (emit_cnt != '0) || eos;
  assign q_push           = in_accept && cmd_valid;
  assign q_cmd.emit_bytes = match ? cfg.replacement_bytes : sfr_pkg::EMIT_W'(nw_flat);
  assign q_cmd.emit_count = emit_cnt;
  assign q_cmd.last       = eos;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
      done_r <= '0;
    end else if (in_accept) begin
      held_r <= held_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      win_r <= win_nxt;
    end
  end

  `SFR_ASSERT_IMPL(a_held_bound, 1'b1, held_r < HW'(P), "window holds a full pattern")
  `SFR_ASSERT_NEXT(a_eos_clears, in_accept && eos, (held_r == '0) && (done_r == '0),
    "string end left state behind")

endmodule

// ===== design/sfr_queue.sv =====
// ----------------------------------------------------------------------------
// sfr_queue
// Short command queue between the front and back ends.
// ----------------------------------------------------------------------------
`include "stream_find_and_replace_defines.svh"

module sfr_queue #(
  parameter int QUEUE_DEPTH = sfr_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_push,
  input  sfr_pkg::cmd_t q_cmd,
  output logic          q_full,
  input  logic          q_pop,
  output sfr_pkg::cmd_t q_head,
  output logic          q_empty
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  sfr_pkg::cmd_t slot_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign q_full  = (count_r == CW'(QUEUE_DEPTH));
  assign q_empty = (count_r == '0);
  assign q_head  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (q_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (q_push && !q_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (q_pop && !q_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      slot_r[wr_ptr_r] <= q_cmd;
    end
  end

  `SFR_ASSERT_IMPL(a_q_no_overflow, q_full, !q_push, "push into full command queue")
  `SFR_ASSERT_IMPL(a_q_no_underflow, q_empty, !q_pop, "pop from empty command queue")

endmodule

// ===== design/sfr_back.sv =====
// ----------------------------------------------------------------------------
// sfr_back
// Expand queued commands into registered result items, one per unstalled cycle.
// ----------------------------------------------------------------------------
`include "stream_find_and_replace_defines.svh"

module sfr_back (
  input  logic               clk,
  input  logic               rst_n,
  input  sfr_pkg::cmd_t      q_head,
  input  logic               q_empty,
  output logic               q_pop,
  output sfr_pkg::out_item_t out_data,
  output logic               empty,
  input  logic               pop
);

  localparam int LW = sfr_pkg::LEN_W;

  logic [sfr_pkg::EMIT_IDX_W-1:0] idx_r, idx_nxt;
  logic [LW-1:0]                  nres, idx_ext;
  logic                           out_valid_r, out_valid_nxt;
  sfr_pkg::out_item_t             out_r, out_nxt;
  logic                           advance, emit, is_final, present;

  // a command with no bytes is a bare end marker: one result
  assign nres     = (q_head.emit_count == '0) ? LW'(1) : q_head.emit_count;
  assign idx_ext  = LW'(idx_r);
  assign is_final = (idx_ext == nres - LW'(1));
  assign present  = (q_head.emit_count != '0);
  assign advance  = !out_valid_r || pop;
  assign emit     = !q_empty && advance;
  assign q_pop    = emit && is_final;

  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    idx_nxt       = idx_r;
    if (emit) begin
      out_nxt.out_byte     = present ? q_head.emit_bytes[8*idx_r +: 8] : 8'h00;
      out_nxt.byte_present = present;
      out_nxt.out_last     = q_head.last && is_final;
      out_valid_nxt        = 1'b1;
      idx_nxt              = is_final ? '0 : idx_r + 1'b1;
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_data = out_r;
  assign empty    = !out_valid_r;

  `SFR_ASSERT_IMPL(a_idx_in_cmd, !q_empty, idx_ext < nres, "byte index past command end")
  `SFR_ASSERT_IMPL(a_idx_idle, q_empty, idx_r == '0, "byte index left over with no command")

endmodule

// ===== design/stream_find_and_replace.sv =====
// ----------------------------------------------------------------------------
// stream_find_and_replace
// Streaming substring find-and-replace over strings of text bytes.
// ----------------------------------------------------------------------------
// Bytes enter through push/full with an end-of-string mark and leave through
// empty/pop, one rewritten byte per item. Up to pattern_length bytes are held
// back; a held run equal to the pattern (leftmost, non-overlapping, at most
// max_replacements per string) is replaced by the replacement bytes, zero of
// them deleting the match. At string end the held bytes are flushed, and a
// string that leaves nothing produces a single item with byte_present low and
// out_last high. Rate: one input item per clock while each item yields at most
// one result and the receiver keeps popping; the back end drives one result
// per clock while the receiver pops, so an item yielding more than one result
// (a replacement or an end-of-string flush, up to 8) keeps it busy, and the
// QUEUE_DEPTH-entry command queue lets the front keep taking items meanwhile.
// Registers sit at byte address 8*index on the 64-bit configuration port;
// write them only while the block is idle.
// ----------------------------------------------------------------------------
module stream_find_and_replace #(
  parameter int MAX_PATTERN_BYTES = sfr_pkg::MAX_PATTERN_BYTES,
  parameter int QUEUE_DEPTH       = sfr_pkg::QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // input item channel
  input  logic                       push,
  output logic                       full,
  input  sfr_pkg::in_item_t          in_data,
  // result item channel
  output logic                       empty,
  input  logic                       pop,
  output sfr_pkg::out_item_t         out_data,
  // configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sfr_pkg::ADDR_W-1:0] paddr,
  input  logic [sfr_pkg::DATA_W-1:0] pwdata,
  output logic [sfr_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  sfr_pkg::cfg_t cfg;
  sfr_pkg::cmd_t q_cmd;
  sfr_pkg::cmd_t q_head;
  logic          q_push;
  logic          q_full;
  logic          q_pop;
  logic          q_empty;

  // configuration registers
  sfr_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // front: hold the window, test for a match, issue commands
  sfr_front #(
    .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .push    (push),
    .full    (full),
    .in_data (in_data),
    .q_push  (q_push),
    .q_cmd   (q_cmd),
    .q_full  (q_full)
  );

  // decouple front and back so each stalls on its own
  sfr_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_push  (q_push),
    .q_cmd   (q_cmd),
    .q_full  (q_full),
    .q_pop   (q_pop),
    .q_head  (q_head),
    .q_empty (q_empty)
  );

  // back: expand each command into result items
  sfr_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_head   (q_head),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .out_data (out_data),
    .empty    (empty),
    .pop      (pop)
  );

endmodule

// ===== tb/stream_find_and_replace_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stream_find_and_replace_tb
// Self-checking bench for the streaming find-and-replace block. Strings of
// text bytes go in through push/full; every rewritten item coming out through
// empty/pop is compared with a cycle-free software copy of the block kept in
// a small tracker class. Settings are changed over the APB port between
// phases, and both sides idle and stall at random.
// ----------------------------------------------------------------------------
module stream_find_and_replace_tb;

  // register slots past the end of the map; writes there must do nothing
  localparam logic [2:0] REG_SPARE_LO = 3'd5;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  localparam int SETTLE_CYCLES   = 12;
  localparam int HOLD_OFF_CYCLES = 300;   // long receiver stall, fills the block
  localparam int PHASE_ITEMS     = 14;
  localparam int RANDOM_PHASES   = 8;
  localparam int TIMEOUT_NS      = 200000;

  // --------------------------------------------------------------------------
  // Tracker: holds the block's settings and window, predicts the rewritten
  // items for each accepted text item and checks them in order.
  // --------------------------------------------------------------------------
  class rewrite_tracker;
    logic [63:0] pattern_bytes;
    logic [3:0]  pattern_len;
    logic [63:0] repl_bytes;
    logic [3:0]  repl_len;
    logic [15:0] max_repl;
    logic [7:0]  held[$];
    logic [15:0] repl_done;
    sfr_pkg::out_item_t expected_rewrites[$];
    int errors, results_seen, items_seen, strings_seen, matches_replaced;

    function new();
      pattern_bytes = '0;
      pattern_len   = 4'd1;
      repl_bytes    = '0;
      repl_len      = '0;
      max_repl      = '0;
      repl_done     = '0;
    endfunction

    function void write_register(logic [2:0] idx, logic [63:0] value);
      case (idx)
        sfr_pkg::REG_PATTERN_BYTES:      pattern_bytes = value;
        sfr_pkg::REG_PATTERN_LENGTH:     pattern_len   = value[3:0];
        sfr_pkg::REG_REPLACEMENT_BYTES:  repl_bytes    = value;
        sfr_pkg::REG_REPLACEMENT_LENGTH: repl_len      = value[3:0];
        sfr_pkg::REG_MAX_REPLACEMENTS:   max_repl      = value[15:0];
        default: ;
      endcase
    endfunction

    function void queue_rewrite(logic [7:0] b, logic present, logic last);
      sfr_pkg::out_item_t r;
      r.out_byte     = b;
      r.byte_present = present;
      r.out_last     = last;
      expected_rewrites.push_back(r);
    endfunction

    function void note_text_item(sfr_pkg::in_item_t it);
      int plen, rlen, i;
      bit hit;
      logic [7:0] emitted[$];
      items_seen++;
      // clamp the lengths the way the block does
      plen = (pattern_len == 0) ? 1 :
             (pattern_len > sfr_pkg::MAX_PATTERN_BYTES) ? sfr_pkg::MAX_PATTERN_BYTES :
             int'(pattern_len);
      rlen = (repl_len > sfr_pkg::MAX_REPLACE_BYTES) ? int'(sfr_pkg::MAX_REPLACE_BYTES) :
             int'(repl_len);
      if (held.size() < 8) held.push_back(it.text_byte);
      if (held.size() >= plen) begin
        // a window longer than the pattern (length lowered) is never tested
        hit = (held.size() == plen) && (repl_done < max_repl);
        for (i = 0; i < plen; i++)
          if (held[i] !== pattern_bytes[8*i +: 8]) hit = 1'b0;
        if (hit) begin
          for (i = 0; i < rlen; i++) emitted.push_back(repl_bytes[8*i +: 8]);
          held.delete();
          repl_done++;
          matches_replaced++;
        end else begin
          while (held.size() > plen - 1) emitted.push_back(held.pop_front());
        end
      end
      if (it.end_of_string) begin
        while (held.size() > 0) emitted.push_back(held.pop_front());
        repl_done = '0;
        strings_seen++;
      end
      foreach (emitted[k])
        queue_rewrite(emitted[k], 1'b1, it.end_of_string && (k == emitted.size() - 1));
      // nothing left of the string: one empty end marker
      if (it.end_of_string && emitted.size() == 0) queue_rewrite(8'h00, 1'b0, 1'b1);
    endfunction

    function void check_rewritten(sfr_pkg::out_item_t got);
      sfr_pkg::out_item_t want;
      results_seen++;
      if (expected_rewrites.size() == 0) begin
        $error("unexpected item: out_byte %0h byte_present %0b out_last %0b",
               got.out_byte, got.byte_present, got.out_last);
        errors++;
        return;
      end
      want = expected_rewrites.pop_front();
      if (got.out_byte !== want.out_byte) begin
        $error("out_byte: expected %0h, got %0h", want.out_byte, got.out_byte);
        errors++;
      end
      if (got.byte_present !== want.byte_present) begin
        $error("byte_present: expected %0b, got %0b", want.byte_present, got.byte_present);
        errors++;
      end
      if (got.out_last !== want.out_last) begin
        $error("out_last: expected %0b, got %0b", want.out_last, got.out_last);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Block under test and its drive signals, all known from time zero
  // --------------------------------------------------------------------------
  logic                       clk      = 1'b0;
  logic                       rst_n    = 1'b0;
  logic                       push     = 1'b0;
  logic                       pop      = 1'b0;
  sfr_pkg::in_item_t          in_data  = '0;
  logic                       psel     = 1'b0;
  logic                       penable  = 1'b0;
  logic                       pwrite   = 1'b0;
  logic [sfr_pkg::ADDR_W-1:0] paddr    = '0;
  logic [sfr_pkg::DATA_W-1:0] pwdata   = '0;
  logic                       full, empty, pready;
  sfr_pkg::out_item_t         out_data;
  logic [sfr_pkg::DATA_W-1:0] prdata;

  int send_idle_pct  = 0;    // chance per cycle the sender sits out
  int recv_stall_pct = 0;    // chance per cycle the receiver holds pop low
  bit hold_req       = 1'b0; // ask the receiver for one long stall
  int hold_left      = 0;

  rewrite_tracker rewrites = new();

  stream_find_and_replace dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_data (in_data),
    .empty   (empty),
    .pop     (pop),
    .out_data(out_data),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Sample both handshakes at the edge; drivers only change things by NBA,
  // so these are the values the block sees.
  always @(posedge clk) begin
    if (rst_n && push && !full) rewrites.note_text_item(in_data);
    if (rst_n && pop && !empty) rewrites.check_rewritten(out_data);
  end

  // Receiver: random stalls, plus a long hold-off counted here on request.
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_OFF_CYCLES;
    end
    if (hold_left > 0) begin
      pop <= 1'b0;
      hold_left--;
    end else begin
      pop <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Offer one text item, idling first at the current rate. Leave push high on
  // return so back-to-back items never drop it for a cycle.
  task automatic send_item(logic [7:0] b, logic eos);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push              <= 1'b1;
    in_data.text_byte <= b;
    in_data.end_of_string <= eos;
    do @(posedge clk); while (full !== 1'b0);
  endtask

  // Send a whole string, marking the final byte.
  task automatic send_text(input logic [7:0] txt[$]);
    foreach (txt[i]) send_item(txt[i], i == txt.size() - 1);
  endtask

  // Setup cycle, access cycle; the register takes the value at the edge where
  // pready is seen high with psel/penable/pwrite.
  task automatic write_reg(logic [2:0] idx, logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    rewrites.write_register(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(logic [63:0] pat, logic [3:0] plen, logic [63:0] repl,
                           logic [3:0] rlen, logic [15:0] maxr);
    write_reg(sfr_pkg::REG_PATTERN_BYTES, pat);
    write_reg(sfr_pkg::REG_PATTERN_LENGTH, {60'd0, plen});
    write_reg(sfr_pkg::REG_REPLACEMENT_BYTES, repl);
    write_reg(sfr_pkg::REG_REPLACEMENT_LENGTH, {60'd0, rlen});
    write_reg(sfr_pkg::REG_MAX_REPLACEMENTS, {48'd0, maxr});
  endtask

  // Drop push, drain every expected item, then wait out SETTLE_CYCLES before
  // anything is reconfigured.
  task automatic settle();
    push <= 1'b0;
    while (rewrites.expected_rewrites.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    logic [7:0]  txt[$];
    logic [63:0] pat;
    logic [15:0] maxr;
    int phase, sent, target, k, r, cut, plen, rlen;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: no replacements allowed, so text passes unchanged even
    // though a zero byte equals the pattern.
    txt = '{8'h00, 8'hFF};
    send_text(txt);
    settle();

    // Length zero acts as one; an empty replacement deletes. A lone deleted
    // byte leaves only the empty end marker.
    configure(64'h61, 4'd0, 64'h0, 4'd0, 16'hFFFF);
    txt = '{8'h61};
    send_text(txt);
    txt = '{8'h62, 8'h61};
    send_text(txt);
    settle();

    // Oversized lengths clamp to eight: eight bytes in, eight bytes out on
    // one item, then a single leftover flushed at the end mark.
    configure('1, 4'd15, 64'h0123_4567_89AB_CDEF, 4'd15, 16'd1);
    txt.delete();
    repeat (9) txt.push_back(8'hFF);
    send_text(txt);
    settle();

    // Lower the pattern length mid-string: the overfull window is emptied
    // without a match test. Spare register slots must be ignored.
    configure(64'h6463_6261, 4'd4, 64'h5958, 4'd2, 16'd2);
    send_item(8'h61, 1'b0);
    send_item(8'h62, 1'b0);
    send_item(8'h63, 1'b0);
    settle();
    write_reg(sfr_pkg::REG_PATTERN_LENGTH, 64'd1);
    write_reg(REG_SPARE_LO, '1);
    write_reg(REG_SPARE_HI, 64'h5A5A_5A5A_5A5A_5A5A);
    send_item(8'h61, 1'b0);
    send_item(8'h61, 1'b1);
    // three matches, limit two: the third passes through
    txt = '{8'h61, 8'h61, 8'h61};
    send_text(txt);
    settle();

    // Random phases: mostly strings stitched from pattern pieces so matches
    // and near-misses are common, with some plain noise strings.
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      plen = (phase == 0) ? 1 : (phase == 1) ? 8 : $urandom_range(1, 8);
      rlen = (phase == 0) ? 8 : (phase == 1) ? 0 : $urandom_range(0, 8);
      maxr = (phase == 2) ? 16'd0 : (phase == 3) ? 16'hFFFF : 16'($urandom_range(1, 3));
      pat  = {$urandom, $urandom};
      configure(pat, 4'(plen), {$urandom, $urandom}, 4'(rlen), maxr);

      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
        default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      // stall the receiver for a long stretch while the sender keeps pushing
      if (phase == 4) hold_req = 1'b1;

      sent = 0;
      while (sent < PHASE_ITEMS) begin
        txt.delete();
        target = $urandom_range(1, 16);
        if ($urandom_range(0, 4) == 0) begin
          repeat (target) txt.push_back(8'($urandom));
        end else begin
          while (txt.size() < target) begin
            r = $urandom_range(0, 9);
            if (r < 4) begin
              for (k = 0; k < plen; k++) txt.push_back(pat[8*k +: 8]);
            end else if (r < 6) begin
              cut = $urandom_range(1, plen);
              for (k = 0; k < cut; k++) txt.push_back(pat[8*k +: 8]);
            end else if (r < 8) begin
              k = $urandom_range(0, plen - 1);
              txt.push_back(pat[8*k +: 8]);
            end else begin
              txt.push_back(8'($urandom));
            end
          end
        end
        send_text(txt);
        sent += txt.size();
      end
      settle();
    end

    // Drain with the receiver always ready, then report.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    settle();
    $display("covered %0d text items in %0d strings, %0d matches replaced",
             rewrites.items_seen, rewrites.strings_seen, rewrites.matches_replaced);
    $display("checked %0d rewritten items over %0d random settings, errors %0d",
             rewrites.results_seen, RANDOM_PHASES, rewrites.errors);
    if (rewrites.errors == 0 && rewrites.expected_rewrites.size() == 0) begin
      $display("stream_find_and_replace_tb OK");
    end else begin
      $display("stream_find_and_replace_tb NOT OK");
    end
    $finish;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #(TIMEOUT_NS);
    $display("stream_find_and_replace_tb NOT OK");
    $finish;
  end

endmodule
